// ===== rtl/sfvd_pkg.sv =====
`default_nettype none

package sfvd_pkg;

   // Code bytes per feature before a continuation bit is ignored.
   localparam int unsigned MAX_CODE_BYTES = 10;

   // Only the two flag bits and the 32 delta bits above them reach a result.
   localparam int unsigned CODE_BITS = 34;

   localparam int unsigned INDEX_BITS_WIDTH = 6;
   localparam logic [INDEX_BITS_WIDTH-1:0] INDEX_BITS_RESET = 6'd18;

   localparam logic [31:0] FLOAT_POS_ONE = 32'h3F80_0000;
   localparam logic [31:0] FLOAT_NEG_ONE = 32'hBF80_0000;

   // Flag bit positions in the decoded code.
   localparam int unsigned FLAG_NEG_ONE = 0;
   localparam int unsigned FLAG_GENERAL = 1;

   localparam logic [7:0] CONT_MASK = 8'h80;

   typedef struct packed {
      logic [31:0] feature_index;
      logic [31:0] value_bits;
      logic        out_of_order;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/sparse_feature_varint_decoder.sv =====
`default_nettype none

// Sparse feature varint decoder.
// req_ channel: one byte of a packed feature block per transaction, with
//   req_segment_start marking the first byte of a namespace block (clears
//   the running index and any partially decoded feature first).
// rsp_ channel: one transaction per completed feature: masked running index,
//   float32 value bits and the out-of-order (negative delta) flag.
// csr_ port: csr_wr_en/csr_wr_data write index_bits, the number of index bits
//   kept; write it only while the block is idle.
// Throughput: one byte per cycle while req_ready is high. All decoding
//   of a byte is done in the cycle it is accepted, from the decode
//   state registers. A result is registered when the byte that completes
//   its feature is accepted: into the output entry, or into the skid entry.
// Stall: the output register is backed by one skid entry, so a byte is still
//   taken while a result waits; req_ready drops only when both are full.
// Reset: clears the decode state and both output entries; index_bits
//   returns to 18.

module sparse_feature_varint_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_segment_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_feature_index,
   output logic [31:0]      rsp_value_bits,
   output logic             rsp_out_of_order
);
   import sfvd_pkg::*;

   logic [INDEX_BITS_WIDTH-1:0] index_bits_ff;
   logic [CODE_BITS-1:0]        code_accum_ff, code_accum_in;
   logic [3:0]                  code_count_ff, code_count_in;
   logic                        reading_value_ff, reading_value_in;
   logic [1:0]                  value_count_ff, value_count_in;
   logic [23:0]                 value_accum_ff, value_accum_in;
   logic [31:0]                 running_index_ff, running_index_in;
   logic [31:0]                 held_index_ff, held_index_in;
   logic                        held_flag_ff, held_flag_in;

   result_type out_ff, out_in, skid_ff, skid_in, res;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       res_fire;
   logic       accept, take;

   // working copies after a segment restart
   logic [CODE_BITS-1:0] code_cur;
   logic [3:0]           count_cur;
   logic                 reading_cur;
   logic [1:0]           vcount_cur;
   logic [23:0]          vaccum_cur;
   logic [31:0]          index_cur;

   logic [6:0]           shift_amt;
   logic [63:0]          group_wide;
   logic [CODE_BITS-1:0] code_new;
   logic [31:0]          zz, delta, index_sum, mask;
   logic [63:0]          mask_wide;
   logic [4:0]           count_next;

   assign accept    = req_valid && req_ready;
   assign take      = out_valid_ff && rsp_ready;
   assign req_ready = !skid_valid_ff;

   assign rsp_valid         = out_valid_ff;
   assign rsp_feature_index = out_ff.feature_index;
   assign rsp_value_bits    = out_ff.value_bits;
   assign rsp_out_of_order  = out_ff.out_of_order;

   always_comb begin
      code_cur    = code_accum_ff;
      count_cur   = code_count_ff;
      reading_cur = reading_value_ff;
      vcount_cur  = value_count_ff;
      vaccum_cur  = value_accum_ff;
      index_cur   = running_index_ff;
      if (req_segment_start) begin
         code_cur    = '0;
         count_cur   = '0;
         reading_cur = 1'b0;
         vcount_cur  = '0;
         vaccum_cur  = '0;
         index_cur   = '0;
      end

      // 7 * count via shift and subtract; count stays below MAX_CODE_BYTES
      shift_amt  = {count_cur, 3'b000} - {3'b000, count_cur};
      group_wide = {57'd0, req_data_byte[6:0]} << shift_amt;
      code_new   = code_cur | group_wide[CODE_BITS-1:0];
      count_next = {1'b0, count_cur} + 5'd1;

      zz        = code_new[CODE_BITS-1:2];
      delta     = zz[0] ? ~{1'b0, zz[31:1]} : {1'b0, zz[31:1]};
      index_sum = index_cur + delta;
      mask_wide = ~({64{1'b1}} << index_bits_ff);
      mask      = mask_wide[31:0];

      code_accum_in    = code_cur;
      code_count_in    = count_cur;
      reading_value_in = reading_cur;
      value_count_in   = vcount_cur;
      value_accum_in   = vaccum_cur;
      running_index_in = index_cur;
      held_index_in    = held_index_ff;
      held_flag_in     = held_flag_ff;

      res_fire          = 1'b0;
      res.feature_index = held_index_ff;
      res.value_bits    = {req_data_byte, vaccum_cur};
      res.out_of_order  = held_flag_ff;

      if (reading_cur) begin
         if (vcount_cur == 2'd3) begin
            res_fire         = 1'b1;
            reading_value_in = 1'b0;
            value_count_in   = '0;
            value_accum_in   = '0;
         end else begin
            value_count_in = vcount_cur + 2'd1;
            case (vcount_cur)
               2'd0:    value_accum_in[7:0]   = req_data_byte;
               2'd1:    value_accum_in[15:8]  = req_data_byte;
               2'd2:    value_accum_in[23:16] = req_data_byte;
               default: value_accum_in        = vaccum_cur;
            endcase
         end
      end else if ((req_data_byte & CONT_MASK) != 8'd0
                   && count_next < 5'(MAX_CODE_BYTES)) begin
         code_accum_in = code_new;
         code_count_in = count_next[3:0];
      end else begin
         // code complete
         running_index_in  = index_sum;
         held_index_in     = index_sum & mask;
         held_flag_in      = delta[31];
         code_accum_in     = '0;
         code_count_in     = '0;
         res.feature_index = index_sum & mask;
         res.out_of_order  = delta[31];
         if (code_new[FLAG_NEG_ONE]) begin
            res_fire       = 1'b1;
            res.value_bits = FLOAT_NEG_ONE;
         end else if (code_new[FLAG_GENERAL]) begin
            reading_value_in = 1'b1;
            value_count_in   = '0;
            value_accum_in   = '0;
         end else begin
            res_fire       = 1'b1;
            res.value_bits = FLOAT_POS_ONE;
         end
      end
   end

   // output register plus one skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = (out_valid_ff && !take) || skid_valid_ff;
      skid_valid_in = skid_valid_ff && !take;
      if (skid_valid_ff && (!out_valid_ff || take)) begin
         out_in = skid_ff;
      end
      if (accept && res_fire) begin
         if (!out_valid_ff || take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff    <= INDEX_BITS_RESET;
         code_accum_ff    <= '0;
         code_count_ff    <= '0;
         reading_value_ff <= 1'b0;
         value_count_ff   <= '0;
         value_accum_ff   <= '0;
         running_index_ff <= '0;
         held_index_ff    <= '0;
         held_flag_ff     <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            index_bits_ff <= csr_wr_data;
         end
         if (accept) begin
            code_accum_ff    <= code_accum_in;
            code_count_ff    <= code_count_in;
            reading_value_ff <= reading_value_in;
            value_count_ff   <= value_count_in;
            value_accum_ff   <= value_accum_in;
            running_index_ff <= running_index_in;
            held_index_ff    <= held_index_in;
            held_flag_ff     <= held_flag_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ===== rtl/sfvd_checker.sv =====
`default_nettype none

module sfvd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_feature_index,
   input wire logic [31:0] rsp_value_bits,
   input wire logic        rsp_out_of_order
);

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transaction");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_feature_index)
         && $stable(rsp_value_bits) && $stable(rsp_out_of_order))
      else $error("rsp payload changed while stalled");

   // backpressure only comes from a full output plus skid entry
   a_ready_needs_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with empty output");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("output not empty after reset");

endmodule

bind sparse_feature_varint_decoder sfvd_checker u_sfvd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_feature_index (rsp_feature_index),
   .rsp_value_bits    (rsp_value_bits),
   .rsp_out_of_order  (rsp_out_of_order)
);

`default_nettype wire

// ===== test/tb_sparse_feature_varint_decoder.sv =====
`default_nettype none

module tb_sparse_feature_varint_decoder;
   import sfvd_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int PHASE_BYTES  = 200;
   localparam int NUM_PHASES   = 7;
   localparam int NUM_DIRECTED = 23;

   typedef struct {
      logic [7:0] data;
      logic       seg;
      bit         typed;
      result_type want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [5:0]  csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_segment_start;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_feature_index;
   logic [31:0] rsp_value_bits;
   logic        rsp_out_of_order;

   // decoder shadow state
   logic [5:0]  keep_bits;
   logic [63:0] code_word;
   int          code_count;
   bit          in_value;
   int          value_count;
   logic [31:0] value_word;
   logic [63:0] run_index;
   logic [31:0] held_index;
   logic        held_neg;

   result_type  pending_features[$];
   int          mismatch_count;
   int          features_checked;
   int          bytes_sent;
   int          idle_cycles;
   bit          req_burst;
   bit          rsp_burst;
   bit          force_restart;

   // Hand-checked rows: simple codes, a float with all bits set, an overlong
   // ten-byte code carrying the largest positive delta plus a bit 63 group,
   // and a segment restart dropping a partial float.
   directed_row_type directed_bytes [NUM_DIRECTED] = '{
      '{8'h00, 1'b1, 1'b1, '{32'h0, FLOAT_POS_ONE, 1'b0}},
      '{8'h01, 1'b0, 1'b1, '{32'h0, FLOAT_NEG_ONE, 1'b0}},
      '{8'h08, 1'b0, 1'b1, '{32'h1, FLOAT_POS_ONE, 1'b0}},
      '{8'h04, 1'b0, 1'b1, '{32'h0, FLOAT_POS_ONE, 1'b1}},
      '{8'h03, 1'b0, 1'b1, '{32'h0, FLOAT_NEG_ONE, 1'b0}},
      '{8'h02, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hFF, 1'b0, 1'b1, '{32'h0, 32'hFFFF_FFFF, 1'b0}},
      '{8'hF8, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hBF, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'h80, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'h80, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'h80, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'h80, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'h81, 1'b0, 1'b1, '{32'h3FFFF, FLOAT_POS_ONE, 1'b0}},
      '{8'h02, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'hAB, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
      '{8'h00, 1'b1, 1'b1, '{32'h0, FLOAT_POS_ONE, 1'b0}}
   };

   sparse_feature_varint_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_segment_start (req_segment_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_feature_index (rsp_feature_index),
      .rsp_value_bits    (rsp_value_bits),
      .rsp_out_of_order  (rsp_out_of_order)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] index_mask(input logic [5:0] n);
      if (n == 6'd0) return 32'h0;
      if (n >= 6'd32) return 32'hFFFF_FFFF;
      return (32'd1 << n) - 32'd1;
   endfunction

   task automatic clear_partial_feature();
      code_word   = '0;
      code_count  = 0;
      in_value    = 1'b0;
      value_count = 0;
      value_word  = '0;
   endtask

   // Advances the shadow decoder by one byte; got is set when a feature completes.
   task automatic decode_feature_byte(input logic [7:0] b, input logic seg,
                                      output bit got, output result_type r);
      int unsigned shift;
      logic [31:0] zz;
      logic [31:0] mag;
      logic [31:0] delta;
      got = 1'b0;
      r   = '0;
      if (seg) begin
         clear_partial_feature();
         run_index = '0;
      end
      if (in_value) begin
         value_word = value_word | ({24'h0, b} << (8 * value_count));
         if (value_count == 3) begin
            got = 1'b1;
            r   = '{feature_index: held_index, value_bits: value_word,
                    out_of_order: held_neg};
            in_value    = 1'b0;
            value_count = 0;
            value_word  = '0;
         end else begin
            value_count++;
         end
      end else begin
         shift = 7 * code_count;
         if (shift < 64)
            code_word = code_word | ({56'h0, b & 8'h7F} << shift);
         if ((b & CONT_MASK) != 8'h0 && code_count + 1 < MAX_CODE_BYTES) begin
            code_count++;
         end else begin
            // zigzag on bits 33:2 only; anything above is dropped
            zz    = code_word[33:2];
            mag   = zz >> 1;
            delta = zz[0] ? ~mag : mag;
            run_index  = run_index + {{32{delta[31]}}, delta};
            held_index = run_index[31:0] & index_mask(keep_bits);
            held_neg   = delta[31];
            if (code_word[FLAG_NEG_ONE]) begin
               got = 1'b1;
               r   = '{feature_index: held_index, value_bits: FLOAT_NEG_ONE,
                       out_of_order: held_neg};
            end else if (code_word[FLAG_GENERAL]) begin
               in_value    = 1'b1;
               value_count = 0;
               value_word  = '0;
            end else begin
               got = 1'b1;
               r   = '{feature_index: held_index, value_bits: FLOAT_POS_ONE,
                       out_of_order: held_neg};
            end
            code_word  = '0;
            code_count = 0;
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch %0d: %s", mismatch_count + 1, msg);
      mismatch_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
                            input result_type want);
      int gap;
      bit got;
      result_type r;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_segment_start <= s;
      do @(posedge clock); while (!req_ready);
      decode_feature_byte(b, s, got, r);
      if (typed) pending_features.push_back(want);
      else if (got) pending_features.push_back(r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic write_index_bits(input logic [5:0] v);
      req_valid <= 1'b0;
      while (pending_features.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      keep_bits = v;
   endtask

   // Mostly well-formed features with random deltas, flags and lengths;
   // a few noise bytes, truncated codes and mid-feature restarts.
   task automatic send_random_feature();
      logic [63:0] code;
      logic [31:0] zz;
      logic [1:0]  flags;
      logic [7:0]  seq [14];
      int          w;
      int          nbytes;
      int          total;
      int          limit;
      bit          overlong;
      if ($urandom_range(0, 99) < 8) begin
         send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
      end else begin
         flags = 2'($urandom);
         w     = $urandom_range(0, 32);
         zz    = (w == 0) ? 32'h0 : ($urandom >> (32 - w));
         code  = {30'h0, zz, flags};
         if ($urandom_range(0, 15) == 0) code[63:34] = 30'($urandom);
         nbytes = 1;
         while (nbytes < MAX_CODE_BYTES && (code >> (7 * nbytes)) != 64'h0) nbytes++;
         if ($urandom_range(0, 9) == 0) nbytes = nbytes + $urandom_range(1, 3);
         if (nbytes > MAX_CODE_BYTES) nbytes = MAX_CODE_BYTES;
         overlong = ($urandom_range(0, 24) == 0);
         if (overlong) nbytes = MAX_CODE_BYTES;
         for (int i = 0; i < nbytes; i++) begin
            // the tenth group only has bit 63 left; upper bits come in as zero
            seq[i] = {1'b0, 7'(code >> (7 * i))};
            if (i < nbytes - 1 || overlong) seq[i] = seq[i] | CONT_MASK;
         end
         total = nbytes;
         if (!flags[FLAG_NEG_ONE] && flags[FLAG_GENERAL]) begin
            for (int i = 0; i < 4; i++) seq[nbytes + i] = 8'($urandom);
            total = nbytes + 4;
         end
         limit = total;
         if (total > 1 && $urandom_range(0, 24) == 0) begin
            limit = $urandom_range(1, total - 1);
            force_restart = $urandom_range(0, 1);
         end
         for (int i = 0; i < limit; i++) begin
            send_byte(seq[i], (i == 0) && (force_restart || $urandom_range(0, 19) == 0),
                      1'b0, '0);
            if (i == 0) force_restart = 1'b0;
         end
      end
   endtask

   // result side: random stall before each transaction, with stall-free stretches
   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            if (pending_features.size() == 0) begin
               report_mismatch($sformatf("unexpected result index %h value %h",
                                         rsp_feature_index, rsp_value_bits));
            end else begin
               want = pending_features.pop_front();
               features_checked++;
               if (rsp_feature_index !== want.feature_index)
                  report_mismatch($sformatf("feature_index got %h expected %h",
                                            rsp_feature_index, want.feature_index));
               if (rsp_value_bits !== want.value_bits)
                  report_mismatch($sformatf("value_bits got %h expected %h",
                                            rsp_value_bits, want.value_bits));
               if (rsp_out_of_order !== want.out_of_order)
                  report_mismatch($sformatf("out_of_order got %b expected %b",
                                            rsp_out_of_order, want.out_of_order));
            end
         end
      end
   end

   initial begin
      logic [5:0] settings [NUM_PHASES];
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_segment_start = 1'b0;
      mismatch_count    = 0;
      features_checked  = 0;
      bytes_sent        = 0;
      req_burst         = 1'b0;
      rsp_burst         = 1'b0;
      force_restart     = 1'b0;
      keep_bits         = INDEX_BITS_RESET;
      run_index         = '0;
      held_index        = '0;
      held_neg          = 1'b0;
      clear_partial_feature();
      settings = '{6'd0, 6'd63, 6'd1, 6'd32, 6'd31, 6'($urandom_range(2, 30)), 6'd18};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_byte(directed_bytes[i].data, directed_bytes[i].seg,
                   directed_bytes[i].typed, directed_bytes[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_index_bits(settings[p]);
         while (bytes_sent < NUM_DIRECTED + (p + 1) * PHASE_BYTES)
            send_random_feature();
         // leave a float half read so the next mask change must not touch it
         if (p % 2 == 1) begin
            send_byte(8'h0A, 1'b0, 1'b0, '0);
            send_byte(8'($urandom), 1'b0, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_features.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);

      $display("sent %0d bytes over %0d index_bits settings plus the reset value",
               bytes_sent, NUM_PHASES);
      $display("checked %0d features, %0d mismatches", features_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
